FILE: sv/fwps_pkg.sv
// shared types and constants of the flash write-protect splitter
package fwps_pkg;

   localparam int REGIONS = 16;
   localparam int AW      = $clog2(REGIONS);
   localparam int CW      = $clog2(REGIONS + 1);
   localparam int EW      = 64;

   localparam logic [31:0] DEFAULT_SECOND = 32'h0000_0096;

   typedef enum logic [1:0] {
      CMD_ENABLE  = 2'd0,
      CMD_ADD     = 2'd1,
      CMD_DISABLE = 2'd2,
      CMD_WRITE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_SKIP   = 2'd1,
      KIND_ACK    = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DEF0,
      ST_DEF1,
      ST_ADD_SCAN,
      ST_ADD_DONE,
      ST_SEG_SCAN,
      ST_SEG_OUT,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      OUT_ACK,
      OUT_REJECT,
      OUT_WHOLE,
      OUT_SEG
   } out_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_DEF0,
      WR_DEF1,
      WR_MERGE,
      WR_APPEND
   } wr_type;

   typedef enum logic [1:0] {
      TOT_HOLD,
      TOT_CLEAR,
      TOT_SET2,
      TOT_INC
   } tot_type;

   typedef struct packed {
      logic    item_load;
      logic    scan_start;
      logic    scan_run;
      logic    cur_adv;
      logic    out_load;
      out_type out_sel;
      wr_type  wr_sel;
      tot_type tot_op;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type item_cmd;
      logic    cnt_zero;
      logic    sec_zero;
      logic    whole;
      logic    tot_zero;
      logic    tot_full;
      logic    hit;
      logic    scan_done;
      logic    seg_last;
      logic    out_free;
   } dp_status_type;

endpackage

FILE: sv/fwps_ram.sv
// generic single write port ram with registered read
module fwps_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/fwps_ctrl.sv
// controller state machine of the write-protect splitter
module fwps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fwps_pkg::dp_status_type status,
   output fwps_pkg::ctrl_cmd_type  cmd
);
   import fwps_pkg::*;

   state_type state_ff, state_in;
   out_type   resp_ff, resp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         resp_ff  <= OUT_ACK;
      end else begin
         state_ff <= state_in;
         resp_ff  <= resp_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      resp_in  = resp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.item_cmd)
               CMD_ENABLE: begin
                  resp_in  = OUT_ACK;
                  state_in = status.tot_zero ? ST_DEF0 : ST_RESP;
               end
               CMD_ADD: begin
                  state_in = (!status.sec_zero && !status.tot_zero) ? ST_ADD_SCAN
                                                                    : ST_ADD_DONE;
               end
               CMD_DISABLE: begin
                  resp_in  = OUT_ACK;
                  state_in = ST_RESP;
               end
               CMD_WRITE: begin
                  priority if (status.cnt_zero) begin
                     resp_in  = OUT_REJECT;
                     state_in = ST_RESP;
                  end else if (status.whole) begin
                     resp_in  = OUT_WHOLE;
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_SEG_SCAN;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DEF0: state_in = ST_DEF1;
         ST_DEF1: state_in = ST_RESP;
         ST_ADD_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_ADD_DONE;
            end
         end
         ST_ADD_DONE: begin
            resp_in  = (!status.hit && status.tot_full) ? OUT_REJECT : OUT_ACK;
            state_in = ST_RESP;
         end
         ST_SEG_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_SEG_OUT;
            end
         end
         ST_SEG_OUT: begin
            if (status.out_free) begin
               state_in = status.seg_last ? ST_IDLE : ST_SEG_SCAN;
            end
         end
         ST_RESP: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.out_sel = OUT_ACK;
      cmd.wr_sel  = WR_NONE;
      cmd.tot_op  = TOT_HOLD;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.item_load = req_valid;
         end
         ST_DECODE: begin
            cmd.scan_start = 1'b1;
            if (status.item_cmd == CMD_DISABLE) begin
               cmd.tot_op = TOT_CLEAR;
            end
         end
         ST_DEF0: cmd.wr_sel = WR_DEF0;
         ST_DEF1: begin
            cmd.wr_sel = WR_DEF1;
            cmd.tot_op = TOT_SET2;
         end
         ST_ADD_SCAN: cmd.scan_run = 1'b1;
         ST_ADD_DONE: begin
            priority if (status.hit) begin
               cmd.wr_sel = WR_MERGE;
            end else if (!status.tot_full) begin
               cmd.wr_sel = WR_APPEND;
               cmd.tot_op = TOT_INC;
            end else begin
               cmd.wr_sel = WR_NONE;
            end
         end
         ST_SEG_SCAN: cmd.scan_run = 1'b1;
         ST_SEG_OUT: begin
            cmd.out_sel = OUT_SEG;
            if (status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.cur_adv    = !status.seg_last;
               cmd.scan_start = !status.seg_last;
            end
         end
         ST_RESP: begin
            cmd.out_sel  = resp_ff;
            cmd.out_load = status.out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

endmodule

FILE: sv/fwps_dp.sv
// datapath: region table, scan trackers, segment arithmetic and result register
module fwps_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  fwps_pkg::ctrl_cmd_type  cmd,
   output fwps_pkg::dp_status_type status,
   input  logic [1:0]             req_cmd,
   input  logic [31:0]            req_sector,
   input  logic [31:0]            req_sector_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [31:0]            rsp_seg_sector,
   output logic [31:0]            rsp_seg_count,
   output logic                   rsp_last
);
   import fwps_pkg::*;

   // latched beat
   cmd_type     cmd_ff;
   logic [31:0] sec_ff, cnt_ff, cur_ff, cur_in;
   logic [32:0] end_ff;

   // table and scan
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          p_vld_ff, p_vld_in;
   logic [AW-1:0] p_idx_ff, p_idx_in;
   logic          rd_en;
   logic [EW-1:0] rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic          best_vld_ff, best_vld_in;
   logic [31:0]   best_start_ff, best_start_in;
   logic [32:0]   best_end_ff, best_end_in;
   logic          hit_vld_ff, hit_vld_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0]   hit_start_ff, hit_start_in;
   logic [31:0]   hit_len_ff, hit_len_in;

   logic [31:0] rd_start, rd_len, sec_m1, nxt;
   logic [32:0] rd_end, merge_sum;
   logic        add_match, seg_match, skip_sel;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    kind_ff, kind_in;
   logic [31:0] seg_sector_ff, seg_sector_in, seg_count_ff, seg_count_in;
   logic        last_ff, last_in;
   logic        out_free;

   fwps_ram #(
      .WIDTH (EW),
      .DEPTH (REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_start  = rd_data[EW-1:32];
   assign rd_len    = rd_data[31:0];
   assign rd_end    = {1'b0, rd_start} + {1'b0, rd_len};
   assign sec_m1    = sec_ff - 32'd1;
   assign add_match = ({1'b0, sec_m1} < rd_end) && (sec_ff > rd_start);
   assign seg_match = ({1'b0, cur_ff} < rd_end) && (end_ff[31:0] > rd_start);

   // scan issue and trackers
   always_comb begin
      idx_in        = idx_ff;
      p_vld_in      = 1'b0;
      p_idx_in      = idx_ff[AW-1:0];
      rd_en         = 1'b0;
      best_vld_in   = best_vld_ff;
      best_start_in = best_start_ff;
      best_end_in   = best_end_ff;
      hit_vld_in    = hit_vld_ff;
      hit_idx_in    = hit_idx_ff;
      hit_start_in  = hit_start_ff;
      hit_len_in    = hit_len_ff;
      if (p_vld_ff) begin
         if (seg_match && (!best_vld_ff || rd_start < best_start_ff)) begin
            best_vld_in   = 1'b1;
            best_start_in = rd_start;
            best_end_in   = rd_end;
         end
         if (add_match && !hit_vld_ff) begin
            hit_vld_in   = 1'b1;
            hit_idx_in   = p_idx_ff;
            hit_start_in = rd_start;
            hit_len_in   = rd_len;
         end
      end
      if (cmd.scan_start) begin
         idx_in      = '0;
         best_vld_in = 1'b0;
         hit_vld_in  = 1'b0;
      end else if (cmd.scan_run && idx_ff != total_ff) begin
         rd_en    = 1'b1;
         p_vld_in = 1'b1;
         idx_in   = idx_ff + CW'(1);
      end
   end

   // segment end from the lowest overlapping region
   always_comb begin
      skip_sel = best_vld_ff && (best_start_ff <= cur_ff);
      priority if (!best_vld_ff) begin
         nxt = end_ff[31:0];
      end else if (skip_sel) begin
         nxt = (best_end_ff < end_ff) ? best_end_ff[31:0] : end_ff[31:0];
      end else begin
         nxt = best_start_ff;
      end
   end

   // table writes
   assign merge_sum = {1'b0, hit_len_ff} + {1'b0, cnt_ff};

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
      unique case (cmd.wr_sel)
         WR_NONE: wr_en = 1'b0;
         WR_DEF0: wr_data = {32'd0, 32'd1};
         WR_DEF1: begin
            wr_addr = AW'(1);
            wr_data = {DEFAULT_SECOND, 32'd1};
         end
         WR_MERGE: begin
            wr_addr = hit_idx_ff;
            wr_data = {hit_start_ff, merge_sum[32] ? 32'hFFFF_FFFF : merge_sum[31:0]};
         end
         WR_APPEND: begin
            wr_addr = total_ff[AW-1:0];
            wr_data = {sec_ff, cnt_ff};
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_comb begin
      unique case (cmd.tot_op)
         TOT_HOLD:  total_in = total_ff;
         TOT_CLEAR: total_in = '0;
         TOT_SET2:  total_in = CW'(2);
         TOT_INC:   total_in = total_ff + CW'(1);
         default:   total_in = total_ff;
      endcase
   end

   assign cur_in = cmd.item_load ? req_sector : (cmd.cur_adv ? nxt : cur_ff);

   // result beat
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      kind_in       = kind_ff;
      seg_sector_in = seg_sector_ff;
      seg_count_in  = seg_count_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         kind_in       = KIND_ACK;
         seg_sector_in = '0;
         seg_count_in  = '0;
         last_in       = 1'b1;
         unique case (cmd.out_sel)
            OUT_ACK:    kind_in = KIND_ACK;
            OUT_REJECT: kind_in = KIND_REJECT;
            OUT_WHOLE: begin
               kind_in       = KIND_WRITE;
               seg_sector_in = sec_ff;
               seg_count_in  = cnt_ff;
            end
            OUT_SEG: begin
               kind_in       = skip_sel ? KIND_SKIP : KIND_WRITE;
               seg_sector_in = cur_ff;
               seg_count_in  = nxt - cur_ff;
               last_in       = (nxt == end_ff[31:0]);
            end
            default: kind_in = KIND_REJECT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         idx_ff       <= '0;
         p_vld_ff     <= 1'b0;
         best_vld_ff  <= 1'b0;
         hit_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         p_vld_ff     <= p_vld_in;
         best_vld_ff  <= best_vld_in;
         hit_vld_ff   <= hit_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         cmd_ff <= cmd_type'(req_cmd);
         sec_ff <= req_sector;
         cnt_ff <= req_sector_count;
         end_ff <= {1'b0, req_sector} + {1'b0, req_sector_count};
      end
      cur_ff        <= cur_in;
      p_idx_ff      <= p_idx_in;
      best_start_ff <= best_start_in;
      best_end_ff   <= best_end_in;
      hit_idx_ff    <= hit_idx_in;
      hit_start_ff  <= hit_start_in;
      hit_len_ff    <= hit_len_in;
      kind_ff       <= kind_in;
      seg_sector_ff <= seg_sector_in;
      seg_count_ff  <= seg_count_in;
      last_ff       <= last_in;
   end

   assign status.item_cmd  = cmd_ff;
   assign status.cnt_zero  = (cnt_ff == 32'd0);
   assign status.sec_zero  = (sec_ff == 32'd0);
   assign status.tot_zero  = (total_ff == '0);
   assign status.whole     = end_ff[32] || (total_ff == '0);
   assign status.tot_full  = (total_ff == CW'(REGIONS));
   assign status.hit       = hit_vld_ff;
   assign status.scan_done = (idx_ff == total_ff) && !p_vld_ff;
   assign status.seg_last  = (nxt == end_ff[31:0]);
   assign status.out_free  = out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_seg_sector = seg_sector_ff;
   assign rsp_seg_count  = seg_count_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: sv/flash_write_protect_splitter_unit.sv
// top level of the flash write-protect splitter
//
// request channel (req_): one beat carries a command, a sector and a count.
//   enable defaults, add region, disable and write request.
// response channel (rsp_): beats of kind write, skip, acknowledge or rejected;
//   rsp_last marks the final beat caused by one request.
// one request is worked on at a time; req_stall is low only when the block
//   is idle, and the next request is taken while the last response waits.
// an add region may scan the stored regions before it answers; the other table
//   commands answer without a scan.
// a write request gives one beat per segment; each segment costs a full scan
//   of the region table through its single read port.
// a held rsp_stall freezes the response register and the controller waits.
// after reset the region table is empty and no response is pending.
module flash_write_protect_splitter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_sector,
   input  logic [31:0] req_sector_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_seg_sector,
   output logic [31:0] rsp_seg_count,
   output logic        rsp_last
);
   import fwps_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fwps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fwps_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cmd          (req_cmd),
      .req_sector       (req_sector),
      .req_sector_count (req_sector_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_seg_sector   (rsp_seg_sector),
      .rsp_seg_count    (rsp_seg_count),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: sv/fwps_checker.sv
// port checker of the flash write-protect splitter and its bind
module fwps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_cmd,
   input logic [31:0] req_sector,
   input logic [31:0] req_sector_count,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_seg_sector,
   input logic [31:0] rsp_seg_count,
   input logic        rsp_last
);
   import fwps_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_seg_sector)
         && $stable(rsp_seg_count) && $stable(rsp_last))
      else $error("stalled response beat changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pending beat or busy after reset");

   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ACK || rsp_kind == KIND_REJECT)
         |-> rsp_seg_sector == 32'd0 && rsp_seg_count == 32'd0 && rsp_last)
      else $error("status beat carries a segment");

   a_seg_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_WRITE || rsp_kind == KIND_SKIP) |-> rsp_seg_count != 32'd0)
      else $error("empty segment");

endmodule

bind flash_write_protect_splitter_unit fwps_checker u_fwps_checker (.*);
